// File: rtl/mqpd_pkg.sv
// Shared types and constants for the MQTT PUBLISH packet deframer.
// Used by the step logic, the top level and the port checker; no dependencies.
package mqpd_pkg;

  localparam int MQPD_MAX_LENGTH_DIGITS = 4;

  localparam logic [3:0] MQPD_TYPE_PUBLISH = 4'h3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_REMLEN  = 3'd1,
    PH_TLEN    = 3'd2,
    PH_TOPIC   = 3'd3,
    PH_MSGID   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_IGNORE  = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    CL_HEADER  = 3'd0,
    CL_REMLEN  = 3'd1,
    CL_TLEN    = 3'd2,
    CL_TOPIC   = 3'd3,
    CL_MSGID   = 3'd4,
    CL_PAYLOAD = 3'd5,
    CL_IGNORED = 3'd6,
    CL_ERROR   = 3'd7
  } class_t;

  typedef struct packed {
    phase_t      phase;
    logic        pub;
    logic [1:0]  qos;
    logic [27:0] acc;
    logic [2:0]  cnt;
    logic [27:0] left;
    logic [15:0] tlen;
    logic [15:0] fc;
  } state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    class_t      byte_class;
    logic        is_publish;
    logic [1:0]  qos_level;
    logic [27:0] remaining_length;
    logic [15:0] topic_length;
    logic [27:0] payload_length;
    logic        last_of_packet;
  } result_t;

endpackage

// File: rtl/mqtt_publish_packet_deframer.sv
// Top level of the MQTT PUBLISH packet deframer: parser state and result register.
// Depends on mqpd_pkg and mqpd_step.
//
//   port group  dir  tdata fields (low bit up)                          tuser            tlast
//   s_*         in   byte_value[7:0]                                    start_of_packet  -
//   m_*         out  data_byte, is_publish, qos_level, remaining_length,
//                    topic_length, payload_length, 5 zero pad bits      byte_class       last
//
// For each byte, the step logic updates the parser state and loads the result
// register at the same edge, so results appear in the cycle after the
// transaction. A new byte is taken every cycle while the result register is
// empty or being read; a stalled output holds s_tready low. Reset (rst,
// synchronous) returns the parser to idle and empties the result register.
module mqtt_publish_packet_deframer
  import mqpd_pkg::*;
#(
  parameter int MAX_LENGTH_DIGITS = MQPD_MAX_LENGTH_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_value
  input  logic        s_tuser,   // start_of_packet
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // data_byte, is_publish, qos_level, remaining_length,
                                 // topic_length, payload_length, zero pad
  output logic [2:0]  m_tuser,   // byte_class
  output logic        m_tlast    // last_of_packet
);

  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t res;
  logic    accept;

  mqpd_step #(
    .MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS)
  ) u_step (
    .cur            (state),
    .byte_value     (s_tdata),
    .start_of_packet(s_tuser),
    .nxt            (state_next),
    .res            (step_res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_IDLE;
      state.pub   <= 1'b0;
      state.qos   <= '0;
      state.acc   <= '0;
      state.cnt   <= '0;
      state.left  <= '0;
      state.tlen  <= '0;
      state.fc    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_res;
    end
  end

  assign m_tdata = {5'b0, res.payload_length, res.topic_length, res.remaining_length,
                    res.qos_level, res.is_publish, res.data_byte};
  assign m_tuser = res.byte_class;
  assign m_tlast = res.last_of_packet;

endmodule

// File: rtl/mqpd_step.sv
// Per-byte parser step: next parser state and the result item for one byte.
// Purely combinational; depends on mqpd_pkg.
module mqpd_step
  import mqpd_pkg::*;
#(
  parameter int MAX_LENGTH_DIGITS = MQPD_MAX_LENGTH_DIGITS
) (
  input  state_t     cur,
  input  logic [7:0] byte_value,
  input  logic       start_of_packet,
  output state_t     nxt,
  output result_t    res
);

  always_comb begin
    class_t      cls;
    logic        last;
    logic        body;
    logic        pay_known;
    logic [4:0]  shamt;
    logic [27:0] acc_new;
    logic [2:0]  cnt_new;
    logic [15:0] tlen_lo;
    logic [15:0] ptl;
    logic [17:0] need;
    logic [27:0] pay;
    logic [15:0] fc_inc;
    logic        keep_err_a;
    logic        keep_err_b;

    nxt        = cur;
    cls        = CL_IGNORED;
    last       = 1'b0;
    body       = 1'b0;
    pay_known  = 1'b0;
    keep_err_a = 1'b0;
    keep_err_b = 1'b0;

    // Each length digit holds seven bits, least significant group first.
    shamt   = {cur.cnt[1:0], 3'b000} - 5'(cur.cnt[1:0]);
    acc_new = cur.acc | (28'(byte_value[6:0]) << shamt);
    cnt_new = cur.cnt + 3'd1;

    tlen_lo = {cur.tlen[15:8], cur.tlen[7:0] | byte_value};
    ptl     = (cur.phase == PH_TLEN) ? tlen_lo : cur.tlen;
    need    = 18'd2 + 18'(ptl) + ((cur.qos != 2'd0) ? 18'd2 : 18'd0);
    pay     = cur.acc - 28'(need);
    fc_inc  = cur.fc + 16'd1;

    if (start_of_packet) begin
      nxt.pub   = (byte_value[7:4] == MQPD_TYPE_PUBLISH);
      nxt.qos   = byte_value[2:1];
      nxt.acc   = '0;
      nxt.cnt   = '0;
      nxt.left  = '0;
      nxt.tlen  = '0;
      nxt.fc    = '0;
      nxt.phase = PH_REMLEN;
      cls       = CL_HEADER;
    end else begin
      case (cur.phase)
        PH_IDLE: begin
          cls = CL_IGNORED;
        end
        PH_REMLEN: begin
          nxt.acc = acc_new;
          nxt.cnt = cnt_new;
          cls     = CL_REMLEN;
          if (byte_value[7]) begin
            if (int'(cnt_new) >= MAX_LENGTH_DIGITS) begin
              cls       = CL_ERROR;
              nxt.left  = '0;
              nxt.phase = PH_ERROR;
            end
          end else begin
            nxt.left = acc_new;
            if (cur.pub && acc_new < 28'd2) begin
              cls = CL_ERROR;
              if (acc_new == '0) begin
                last      = 1'b1;
                nxt.phase = PH_IDLE;
              end else begin
                nxt.phase = PH_ERROR;
              end
            end else if (acc_new == '0) begin
              last      = 1'b1;
              nxt.phase = PH_IDLE;
            end else begin
              nxt.fc    = '0;
              nxt.phase = cur.pub ? PH_TLEN : PH_IGNORE;
            end
          end
        end
        default: begin
          body = 1'b1;
        end
      endcase
    end

    if (body) begin
      nxt.left = (cur.left != '0) ? cur.left - 28'd1 : '0;
      case (cur.phase)
        PH_TLEN: begin
          cls = CL_TLEN;
          if (cur.fc == '0) begin
            nxt.tlen = {byte_value, 8'h00};
            nxt.fc   = 16'd1;
          end else begin
            nxt.tlen = tlen_lo;
            nxt.fc   = '0;
            if ({10'b0, need} > cur.acc) begin
              cls       = CL_ERROR;
              nxt.phase = PH_ERROR;
            end else if (tlen_lo != '0) begin
              nxt.phase = PH_TOPIC;
            end else begin
              nxt.phase = (cur.qos != 2'd0) ? PH_MSGID : PH_PAYLOAD;
            end
          end
        end
        PH_TOPIC: begin
          cls = CL_TOPIC;
          if (fc_inc >= cur.tlen) begin
            nxt.fc    = '0;
            nxt.phase = (cur.qos != 2'd0) ? PH_MSGID : PH_PAYLOAD;
          end else begin
            nxt.fc = fc_inc;
          end
        end
        PH_MSGID: begin
          cls = CL_MSGID;
          if (fc_inc >= 16'd2) begin
            nxt.fc    = '0;
            nxt.phase = PH_PAYLOAD;
          end else begin
            nxt.fc = fc_inc;
          end
        end
        PH_PAYLOAD: cls = CL_PAYLOAD;
        PH_IGNORE:  cls = CL_IGNORED;
        default:    cls = CL_ERROR;
      endcase

      pay_known = nxt.phase inside {PH_TOPIC, PH_MSGID, PH_PAYLOAD};

      // Errors whose length is unknown never end on their own; they wait
      // for the next start mark.
      keep_err_a = (nxt.phase == PH_ERROR) && (cur.acc == '0) && (cls == CL_ERROR)
                   && !cur.pub;
      keep_err_b = (nxt.phase == PH_ERROR) && (int'(cur.cnt) >= MAX_LENGTH_DIGITS)
                   && (cls == CL_ERROR) && (nxt.fc == '0) && (nxt.tlen == '0)
                   && (cur.cnt != '0) && !pay_known;
      if (nxt.left == '0 && !keep_err_a && !keep_err_b) begin
        last      = 1'b1;
        nxt.phase = PH_IDLE;
      end
    end

    res.data_byte        = byte_value;
    res.byte_class       = cls;
    res.is_publish       = nxt.pub;
    res.qos_level        = nxt.qos;
    res.remaining_length = nxt.acc;
    res.topic_length     = nxt.tlen;
    res.payload_length   = pay_known ? pay : '0;
    res.last_of_packet   = last;
  end

endmodule

// File: rtl/mqpd_checker.sv
// Port-level checker for the MQTT PUBLISH packet deframer, bound to the top level.
// Depends on mqpd_pkg and mqtt_publish_packet_deframer.
module mqpd_checker
  import mqpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // Every input transaction shows up as a result in the next cycle, byte unchanged.
  a_pass: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid && m_tdata[7:0] == $past(s_tdata))
    else $error("input byte not passed to the result register");

  // A fixed header byte never closes a packet.
  a_hdr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == CL_HEADER |-> !m_tlast)
    else $error("header byte marked as last");

  // Topic, message id and payload bytes only occur in PUBLISH packets.
  a_pub: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == CL_TOPIC || m_tuser == CL_MSGID || m_tuser == CL_PAYLOAD)
    |-> m_tdata[8])
    else $error("body class outside a PUBLISH packet");

  // A message id is parsed only when QoS is nonzero.
  a_qos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == CL_MSGID |-> m_tdata[10:9] != 2'd0)
    else $error("message id with QoS zero");

endmodule

bind mqtt_publish_packet_deframer mqpd_checker u_mqpd_checker (.*);
